FILE: rtl/sfm_pkg.sv
// Shared types, constants and helper functions of the fp16 sigmoid block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sfm_pkg;

  // Binary16 and binary32 codes.
  localparam logic [15:0] HalfOne  = 16'h3C00;
  localparam logic [15:0] HalfQnan = 16'h7E00;
  localparam logic [31:0] F32Pinf  = 32'h7F80_0000;

  // Magnitudes at and above which the result saturates (20.0 and 18.0).
  localparam logic [14:0] MagPosSat = 15'h4D00;
  localparam logic [14:0] MagNegSat = 15'h4C80;

  // Fixed-point constants in Q2.62: one, and exp(-2^-24) used as squaring seed.
  localparam logic [63:0] FixOne  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ExpSeed = 64'h3FFF_FFC0_0000_2000;

  // 127 scaled by 16 so that the mantissa quotient stays within [0.5, 2).
  localparam logic [63:0] Den127 = 64'd2032;

  // Argument bits (5 integer, 24 fraction), last bit index, normalize limit.
  localparam int unsigned ArgBits = 29;
  localparam logic [4:0]  LastBit = 5'd28;
  localparam logic [3:0]  NormMax = 4'd13;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_to_c;
    logic shift_a;
    logic div_sig;
    logic norm_init;
    logic norm_step;
    logic round_sig;
    logic max_upd;
    logic dn_start;
    logic dn_store;
    logic up_start;
    logic up_store;
    logic push;
  } sfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic last;
    logic a_bit;
    logic mul_done;
    logic div_done;
    logic norm_done;
    logic max_zero;
    logic out_busy;
  } sfm_sts_t;

  // Pack a quotient in [0.5, 2) (bit 63 weighs 1) with base exponent b into a
  // binary32 pattern, rounding to nearest even.
  function automatic logic [31:0] f32_pack(input logic [63:0] q, input logic stk,
                                           input logic signed [6:0] b);
    logic [23:0]       m;
    logic              rb;
    logic              st;
    logic              inc;
    logic signed [9:0] bx;
    logic [9:0]        eb;
    bx = {{3{b[6]}}, b};
    if (q[63]) begin
      m  = q[63:40];
      rb = q[39];
      st = (|q[38:0]) | stk;
      eb = 10'(bx + 10'sd126);
    end else begin
      m  = q[62:39];
      rb = q[38];
      st = (|q[37:0]) | stk;
      eb = 10'(bx + 10'sd125);
    end
    inc = rb & (st | m[0]);
    return {1'b0, eb[7:0], 23'b0} + {8'b0, m} + {31'b0, inc};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sfm_ctrl.sv
// Controller state machine of the fp16 sigmoid block.
// Depends on sfm_pkg for the command and status structs.
`default_nettype none

module sfm_ctrl import sfm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sfm_sts_t sts_i,
  output sfm_cmd_t      cmd_o
);

  typedef enum logic [14:0] {
    StIdle  = 15'b000000000000001,
    StBit   = 15'b000000000000010,
    StMacc  = 15'b000000000000100,
    StSqChk = 15'b000000000001000,
    StMsq   = 15'b000000000010000,
    StDiv   = 15'b000000000100000,
    StNinit = 15'b000000001000000,
    StNorm  = 15'b000000010000000,
    StFin   = 15'b000000100000000,
    StScl   = 15'b000001000000000,
    StDn    = 15'b000010000000000,
    StDnUp  = 15'b000100000000000,
    StUp    = 15'b001000000000000,
    StUpSt  = 15'b010000000000000,
    StPush  = 15'b100000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] bidx_q, bidx_d;

  // State register and argument bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bidx_q  <= '0;
    end else begin
      state_q <= state_d;
      bidx_q  <= bidx_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    bidx_d  = bidx_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bidx_d     = '0;
          state_d    = StBit;
        end
      end
      StBit: begin
        if (sts_i.special) begin
          state_d = StFin;
        end else if (sts_i.a_bit) begin
          cmd_o.mul_start = 1'b1;
          state_d         = StMacc;
        end else begin
          state_d = StSqChk;
        end
      end
      StMacc: begin
        if (sts_i.mul_done) begin
          state_d = StSqChk;
        end
      end
      StSqChk: begin
        if (bidx_q == LastBit) begin
          cmd_o.div_sig = 1'b1;
          state_d       = StDiv;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_to_c  = 1'b1;
          cmd_o.shift_a   = 1'b1;
          bidx_d          = bidx_q + 5'd1;
          state_d         = StMsq;
        end
      end
      StMsq: begin
        if (sts_i.mul_done) begin
          state_d = StBit;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StNinit;
        end
      end
      StNinit: begin
        cmd_o.norm_init = 1'b1;
        state_d         = StNorm;
      end
      StNorm: begin
        if (sts_i.norm_done) begin
          cmd_o.round_sig = 1'b1;
          state_d         = StFin;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      StFin: begin
        cmd_o.max_upd = 1'b1;
        state_d       = sts_i.last ? StScl : StPush;
      end
      StScl: begin
        if (sts_i.max_zero) begin
          state_d = StPush;
        end else begin
          cmd_o.dn_start = 1'b1;
          state_d        = StDn;
        end
      end
      // The down scale comes from a fold by 127, not from the divider.
      StDn: begin
        state_d = StDnUp;
      end
      StDnUp: begin
        cmd_o.dn_store = 1'b1;
        cmd_o.up_start = 1'b1;
        state_d        = StUp;
      end
      StUp: begin
        if (sts_i.div_done) begin
          state_d = StUpSt;
        end
      end
      StUpSt: begin
        cmd_o.up_store = 1'b1;
        state_d        = StPush;
      end
      StPush: begin
        if (!sts_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sfm_dpath.sv
// Datapath of the fp16 sigmoid block: exp by squaring, shared multiplier and
// divider, rounding, running maximum, scale packing and the output register.
// Depends on sfm_pkg; driven by sfm_ctrl.
`default_nettype none

module sfm_dpath import sfm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] sample_half_i,
  input  wire logic        last_item_i,
  input  wire sfm_cmd_t    cmd_i,
  output sfm_sts_t         sts_o,
  output logic [15:0]      sigmoid_half_o,
  output logic             is_last_o,
  output logic [15:0]      max_half_o,
  output logic [31:0]      scale_down_o,
  output logic [31:0]      scale_up_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  // Item registers.
  logic [ArgBits-1:0] a_q;
  logic               neg_q, last_q, spec_q, nan_q;
  logic [15:0]        res_q;
  logic [63:0]        acc_q, c_q;
  logic [15:0]        mx_q;

  // Multiplier registers.
  logic [2:0]   mph_q;
  logic         mbusy_q, mdst_q;
  logic [63:0]  pp_q;
  logic [127:0] macc_q;

  // Divider registers.
  logic [64:0] rem_q;
  logic [63:0] dden_q, quo_q;
  logic [5:0]  dcnt_q;
  logic        dbusy_q;
  logic [3:0]  sh_q;
  logic signed [6:0] be_q;
  logic [31:0] sd_q, su_q;

  // Output registers.
  logic        ov_q;
  logic [15:0] osig_q, omax_q;
  logic        olast_q;
  logic [31:0] osd_q, osu_q;

  // Input decode.
  logic [4:0]         in_ef;
  logic [9:0]         in_fr;
  logic               in_nan, in_spec;
  logic [15:0]        in_res;
  logic [ArgBits-1:0] in_arg;
  logic [4:0]         in_sh;

  always_comb begin
    in_ef   = sample_half_i[14:10];
    in_fr   = sample_half_i[9:0];
    in_nan  = (in_ef == 5'h1F) && (in_fr != '0);
    in_spec = in_nan || (in_ef == 5'h1F) ||
              (!sample_half_i[15] && (sample_half_i[14:0] >= MagPosSat)) ||
              (sample_half_i[15] && (sample_half_i[14:0] >= MagNegSat));
    if (in_nan) begin
      in_res = HalfQnan;
    end else begin
      in_res = sample_half_i[15] ? 16'h0000 : HalfOne;
    end
    in_sh  = (in_ef == '0) ? 5'd0 : (in_ef - 5'd1);
    in_arg = ({18'b0, (in_ef != '0), in_fr} << in_sh);
  end

  // Multiplier operand selection and partial product alignment.
  logic [63:0]  mx_op;
  logic [31:0]  mopa, mopb;
  logic [1:0]   pidx;
  logic [127:0] pp_al, msum;

  always_comb begin
    mx_op = mdst_q ? c_q : acc_q;
    case (mph_q[1:0])
      2'd0:    begin mopa = mx_op[31:0];  mopb = c_q[31:0];  end
      2'd1:    begin mopa = mx_op[31:0];  mopb = c_q[63:32]; end
      2'd2:    begin mopa = mx_op[63:32]; mopb = c_q[31:0];  end
      default: begin mopa = mx_op[63:32]; mopb = c_q[63:32]; end
    endcase
    pidx = 2'(mph_q - 3'd1);
    case (pidx)
      2'd0:    pp_al = {64'b0, pp_q};
      2'd1:    pp_al = {32'b0, pp_q, 32'b0};
      2'd2:    pp_al = {32'b0, pp_q, 32'b0};
      default: pp_al = {pp_q, 64'b0};
    endcase
    msum = macc_q + pp_al;
  end

  logic mul_done;
  assign mul_done = mbusy_q && (mph_q == 3'd4);

  // Divider step: one quotient bit a cycle.
  logic        dcmp;
  logic [64:0] rem_sub;
  logic        div_done;
  assign dcmp     = (rem_q >= {1'b0, dden_q});
  assign rem_sub  = dcmp ? (rem_q - {1'b0, dden_q}) : rem_q;
  assign div_done = dbusy_q && (dcnt_q == 6'd63);

  // Divider start operands.
  logic        dstart;
  logic [64:0] dnum;
  logic [63:0] dden;

  // Normalize the running maximum for the scale computations.
  logic [10:0]       mm;
  logic signed [6:0] em;
  logic [3:0]        lead, sub_sh;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (mx_q[i]) begin
        lead = 4'(i);
      end
    end
    sub_sh = 4'd10 - lead;
    if (mx_q[14:10] == '0) begin
      mm = 11'({1'b0, mx_q[9:0]} << sub_sh);
      em = -7'sd14 - $signed({3'b0, sub_sh});
    end else begin
      mm = {1'b1, mx_q[9:0]};
      em = $signed({2'b0, mx_q[14:10]}) - 7'sd15;
    end
  end

  // Down scale quotient mm / 2032. Since 128 = 127 + 1, folding the upper bits
  // onto the lower seven gives mm = 127 * Q + R, and R / 127 is R repeated in
  // 7-bit groups, so the quotient is exact and the tail is nonzero iff R is.
  logic [7:0]  d7_sum, d7_rem;
  logic [4:0]  d7_quo;
  logic [63:0] dn_quo;
  logic        dn_stk;

  always_comb begin
    d7_sum = {4'b0, mm[10:7]} + {1'b0, mm[6:0]};
    if (d7_sum >= 8'd127) begin
      d7_quo = {1'b0, mm[10:7]} + 5'd1;
      d7_rem = d7_sum - 8'd127;
    end else begin
      d7_quo = {1'b0, mm[10:7]};
      d7_rem = d7_sum;
    end
    dn_quo = {d7_quo, {8{d7_rem[6:0]}}, d7_rem[6:4]};
    dn_stk = (d7_rem != '0);
  end

  always_comb begin
    dstart = cmd_i.div_sig | cmd_i.up_start;
    if (cmd_i.div_sig) begin
      dnum = {1'b0, (neg_q ? acc_q : FixOne)};
      dden = FixOne + acc_q;
    end else begin
      dnum = {1'b0, Den127};
      dden = {53'b0, mm};
    end
  end

  // Rounding of the normalized sigmoid quotient.
  logic        stk, sinc;
  logic [11:0] sn;
  logic [15:0] sres;
  assign stk  = |rem_q;
  assign sinc = quo_q[52] & ((|quo_q[51:0]) | stk | quo_q[53]);
  assign sn   = {1'b0, quo_q[63:53]} + {11'b0, sinc};
  assign sres = {2'b0, 4'(NormMax - sh_q), 10'b0} + {4'b0, sn};

  // Item and exp registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= in_arg;
      neg_q  <= sample_half_i[15];
      last_q <= last_item_i;
      spec_q <= in_spec;
      nan_q  <= in_nan;
      res_q  <= in_res;
      acc_q  <= FixOne;
      c_q    <= ExpSeed;
    end else begin
      if (cmd_i.shift_a) begin
        a_q <= a_q >> 1;
      end
      if (mul_done) begin
        if (mdst_q) begin
          c_q <= msum[125:62];
        end else begin
          acc_q <= msum[125:62];
        end
      end
      if (cmd_i.round_sig) begin
        res_q <= sres;
      end
    end
  end

  // Multiplier sequencer: four partial products, one a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mph_q   <= '0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
      mph_q   <= '0;
    end else if (mbusy_q) begin
      mph_q <= mph_q + 3'd1;
      if (mph_q == 3'd4) begin
        mbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mdst_q <= cmd_i.mul_to_c;
      macc_q <= '0;
    end else if (mbusy_q) begin
      pp_q <= mopa * mopb;
      if (mph_q != 3'd0) begin
        macc_q <= msum;
      end
    end
  end

  // Divider control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (dstart) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (dcnt_q == 6'd63) begin
        dbusy_q <= 1'b0;
      end
    end
  end

  // Divider payload, normalize shifter and scale results.
  always_ff @(posedge clk_i) begin
    if (dstart) begin
      rem_q  <= dnum;
      dden_q <= dden;
      quo_q  <= '0;
    end else if (dbusy_q) begin
      rem_q <= {rem_sub[63:0], 1'b0};
      quo_q <= {quo_q[62:0], dcmp};
    end else if (cmd_i.norm_init) begin
      quo_q <= {quo_q[62:0], 1'b0};
    end else if (cmd_i.norm_step) begin
      quo_q <= {quo_q[62:0], 1'b0};
    end
    if (cmd_i.norm_init) begin
      sh_q <= '0;
    end else if (cmd_i.norm_step) begin
      sh_q <= sh_q + 4'd1;
    end
    if (cmd_i.dn_start) begin
      be_q <= em - 7'sd6;
    end else if (cmd_i.up_start) begin
      be_q <= 7'sd6 - em;
    end
    if (cmd_i.dn_store) begin
      sd_q <= f32_pack(dn_quo, dn_stk, be_q);
    end
    if (cmd_i.up_store) begin
      su_q <= f32_pack(quo_q, stk, be_q);
    end
  end

  // Running maximum over non-NaN results; cleared after the last item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx_q <= '0;
    end else if (cmd_i.max_upd) begin
      if (!nan_q && (res_q > mx_q)) begin
        mx_q <= res_q;
      end
    end else if (cmd_i.push && last_q) begin
      mx_q <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.push) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      osig_q  <= res_q;
      olast_q <= last_q;
      if (!last_q) begin
        omax_q <= '0;
        osd_q  <= '0;
        osu_q  <= '0;
      end else if (mx_q == '0) begin
        omax_q <= '0;
        osd_q  <= '0;
        osu_q  <= F32Pinf;
      end else begin
        omax_q <= mx_q;
        osd_q  <= sd_q;
        osu_q  <= su_q;
      end
    end
  end

  assign sigmoid_half_o = osig_q;
  assign is_last_o      = olast_q;
  assign max_half_o     = omax_q;
  assign scale_down_o   = osd_q;
  assign scale_up_o     = osu_q;
  assign out_valid_o    = ov_q;

  // Status to the controller.
  always_comb begin
    sts_o           = '0;
    sts_o.special   = spec_q;
    sts_o.last      = last_q;
    sts_o.a_bit     = a_q[0];
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.norm_done = quo_q[63] || (sh_q == NormMax);
    sts_o.max_zero  = (mx_q == '0);
    sts_o.out_busy  = ov_q && !out_ready_i;
  end

endmodule

`default_nettype wire

FILE: rtl/sigmoid_fp16_with_max_scale.sv
// Saturating or NaN inputs skip the arithmetic; other items run the exp loop
// on the shared 4-pass multiplier, then the 64-step divider and
// normalization. A last item also runs the down scale fold and the up scale
// division, both skipped with a zero max.
// Throughput: one item at a time; the output register frees the input side.
// Reset: asynchronous, active low; clears control state and the running max.
`default_nettype none

module sigmoid_fp16_with_max_scale import sfm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_half_i,
  input  wire logic        last_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      sigmoid_half_o,
  output logic             is_last_o,
  output logic [15:0]      max_half_o,
  output logic [31:0]      scale_down_o,
  output logic [31:0]      scale_up_o
);

  sfm_cmd_t cmd;
  sfm_sts_t sts;

  // Sequencer.
  sfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register.
  sfm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_half_i  (sample_half_i),
    .last_item_i    (last_item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sigmoid_half_o (sigmoid_half_o),
    .is_last_o      (is_last_o),
    .max_half_o     (max_half_o),
    .scale_down_o   (scale_down_o),
    .scale_up_o     (scale_up_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

`default_nettype wire

FILE: rtl/sfm_checker.sv
// Port-level checks of the fp16 sigmoid block, bound to the top level.
// Depends on sfm_pkg for the result codes.
`default_nettype none

module sfm_checker import sfm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] sigmoid_half_o,
  input wire logic        is_last_o,
  input wire logic [15:0] max_half_o,
  input wire logic [31:0] scale_down_o,
  input wire logic [31:0] scale_up_o
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sigmoid_half_o))
    else $error("stalled result item changed");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Scale fields are zero except on the last item.
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |->
      max_half_o == 16'h0 && scale_down_o == 32'h0 && scale_up_o == 32'h0)
    else $error("scale fields set on a non-last item");

  // A zero maximum gives an infinite up scale.
  a_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o && max_half_o == 16'h0 |-> scale_up_o == F32Pinf)
    else $error("zero maximum without infinite scale");

  // Results lie in [0, 1] or are the quiet NaN.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sigmoid_half_o <= HalfOne || sigmoid_half_o == HalfQnan)
    else $error("result out of range");

endmodule

bind sigmoid_fp16_with_max_scale sfm_checker u_sfm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sigmoid_half_o (sigmoid_half_o),
  .is_last_o      (is_last_o),
  .max_half_o     (max_half_o),
  .scale_down_o   (scale_down_o),
  .scale_up_o     (scale_up_o)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench of the fp16 sigmoid block with running max and scales.
// Depends on sfm_pkg and sigmoid_fp16_with_max_scale; predicts results in real math.
`timescale 1ns / 100ps

module testbench;
  import sfm_pkg::*;

  typedef struct {
    logic [15:0] half;
    logic        last;
  } elem_t;

  typedef struct {
    logic [15:0] sig;
    logic        last;
    logic [15:0] maxh;
    logic [31:0] down;
    logic [31:0] up;
  } sig_res_t;

  localparam int CycleLimit = 6000000;
  localparam int DrainCycles = 800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_half_i = '0;
  logic        last_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] sigmoid_half_o;
  logic        is_last_o;
  logic [15:0] max_half_o;
  logic [31:0] scale_down_o;
  logic [31:0] scale_up_o;

  elem_t    elem_q[$];
  sig_res_t sig_exp_q[$];
  logic [15:0] tensor_max = '0;
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int total_items = 1;
  int err_cnt = 0;
  int cycle_cnt = 0;

  sigmoid_fp16_with_max_scale i_dut (.*);

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic real pow2(int k);
    real r;
    r = 1.0;
    while (k > 0) begin r = r * 2.0; k--; end
    while (k < 0) begin r = r * 0.5; k++; end
    return r;
  endfunction

  // Exponential by range reduction and a Taylor series.
  function automatic real exp_approx(real a);
    real t;
    real r;
    real p;
    int  k;
    t = a * 1.4426950408889634;
    k = $rtoi(t + (t >= 0.0 ? 0.5 : -0.5));
    r = a - real'(k) * 6.93147180369123816490e-01 - real'(k) * 1.90821492927058770002e-10;
    p = 1.0;
    for (int i = 20; i >= 1; i--) p = 1.0 + r * p / real'(i);
    return p * pow2(k);
  endfunction

  // Round a value in [0,1] to binary16, nearest even.
  function automatic logic [15:0] to_half(real s);
    int          e;
    real         q;
    real         frac;
    logic [31:0] n;
    e = -1;
    if (s >= 1.0) return HalfOne;
    if (s <= 0.0) return 16'h0000;
    while (e > -14 && s < pow2(e)) e--;
    if (s < pow2(-14)) begin
      q = s * pow2(24);
    end else begin
      q = s * pow2(10 - e);
    end
    n = $rtoi(q);
    frac = q - real'(n);
    if (frac > 0.5 || (frac == 0.5 && n[0])) n++;
    if (s < pow2(-14)) return n[15:0];
    return 16'(((e + 15) << 10) + (n - 1024));
  endfunction

  function automatic real half_to_real(logic [15:0] h);
    real v;
    if (h[14:10] == 5'd0) v = real'(h[9:0]) * pow2(-24);
    else v = real'({1'b1, h[9:0]}) * pow2(int'(h[14:10]) - 25);
    return h[15] ? -v : v;
  endfunction

  // Double to binary32, nearest even; only normal results occur here.
  function automatic logic [31:0] to_single(real d);
    logic [63:0] b;
    logic [31:0] e32;
    b = $realtobits(d);
    e32 = 32'(b[62:52]) - 32'd1023 + 32'd127;
    return {1'b0, e32[7:0], b[51:29]}
           + 32'(b[28] & ((|b[27:0]) | b[29]));
  endfunction

  // Expected result of one element; updates the tensor maximum.
  function automatic sig_res_t sigmoid_predict(elem_t it);
    sig_res_t r;
    logic     nan;
    real      v;
    real      m;
    nan = 1'b0;
    if (it.half[14:10] == 5'h1F) begin
      if (it.half[9:0] != 0) begin
        nan = 1'b1;
        r.sig = HalfQnan;
      end else begin
        r.sig = it.half[15] ? 16'h0000 : HalfOne;
      end
    end else begin
      v = half_to_real(it.half);
      if (v >= 20.0) r.sig = HalfOne;
      else if (v <= -18.0) r.sig = 16'h0000;
      else r.sig = to_half(1.0 / (1.0 + exp_approx(-v)));
    end
    if (!nan && r.sig > tensor_max) tensor_max = r.sig;
    r.last = it.last;
    r.maxh = '0;
    r.down = '0;
    r.up = '0;
    if (it.last) begin
      r.maxh = tensor_max;
      if (tensor_max == 0) begin
        r.up = F32Pinf;
      end else begin
        m = half_to_real(tensor_max);
        r.down = to_single(m / 127.0);
        r.up = to_single(127.0 / m);
      end
      tensor_max = '0;
    end
    return r;
  endfunction

  function automatic int phase_of();
    return (accepted_cnt * 3) / total_items;
  endfunction

  // Sender: loads the next item at the falling edge once the last one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && issued_cnt == accepted_cnt) begin
      if (elem_q.size() == 0 ||
          (phase_of() == 0 && $urandom_range(99) < 31) ||
          (phase_of() == 1 && $urandom_range(99) < 81)) begin
        in_valid_i <= 1'b0;
      end else begin
        sample_half_i <= elem_q[0].half;
        last_item_i <= elem_q[0].last;
        in_valid_i <= 1'b1;
        elem_q.pop_front();
        issued_cnt++;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (phase_of() == 0) out_ready_i <= ($urandom_range(99) >= 81);
    else if (phase_of() == 1) out_ready_i <= ($urandom_range(99) >= 31);
    else out_ready_i <= 1'b1;
  end

  // Input acceptance and prediction.
  always @(posedge clk_i) begin
    elem_t it;
    if (in_valid_i && in_ready_o) begin
      it.half = sample_half_i;
      it.last = last_item_i;
      sig_exp_q.push_back(sigmoid_predict(it));
      accepted_cnt++;
    end
  end

  // Output check against the oldest expected result.
  always @(posedge clk_i) begin
    sig_res_t e;
    if (out_valid_o && out_ready_i) begin
      if (sig_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result sig=%h", sigmoid_half_o);
      end else begin
        e = sig_exp_q.pop_front();
        if (e.sig !== sigmoid_half_o || e.last !== is_last_o || e.maxh !== max_half_o ||
            e.down !== scale_down_o || e.up !== scale_up_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch exp %h %b %h %h %h got %h %b %h %h %h",
                     e.sig, e.last, e.maxh, e.down, e.up, sigmoid_half_o,
                     is_last_o, max_half_o, scale_down_o, scale_up_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("sigmoid_fp16_with_max_scale regression: fail");
      $finish;
    end
  end

  task automatic add_elem(logic [15:0] h, logic l);
    elem_t it;
    it.half = h;
    it.last = l;
    elem_q.push_back(it);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [15:0] h;
    int          len;
    // Directed: zeros, infinities, NaNs, extremes, saturation edges, subnormals.
    add_elem(16'h0000, 1'b0);
    add_elem(16'h8000, 1'b1);
    add_elem(16'h7C00, 1'b0);
    add_elem(16'hFC00, 1'b1);
    add_elem(16'h7E00, 1'b1);
    add_elem(16'hFC00, 1'b1);
    add_elem(16'h7C01, 1'b0);
    add_elem(16'hFFFF, 1'b0);
    add_elem(16'h7BFF, 1'b0);
    add_elem(16'hFBFF, 1'b1);
    add_elem(16'h0001, 1'b0);
    add_elem(16'h8001, 1'b1);
    add_elem(16'h4D00, 1'b0);
    add_elem(16'hCC80, 1'b0);
    add_elem(16'h4CFF, 1'b0);
    add_elem(16'hCC7F, 1'b1);
    add_elem(16'hCC00, 1'b1);
    add_elem(16'hCA00, 1'b0);
    add_elem(16'h3C00, 1'b0);
    add_elem(16'hBC00, 1'b1);
    add_elem(16'h03FF, 1'b0);
    add_elem(16'h83FF, 1'b1);
    // Random tensors, mostly in the active range of the curve.
    while (elem_q.size() < 1020) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) < 2) h = 16'($urandom());
        else h = {1'($urandom()), 5'($urandom_range(0, 19)), 10'($urandom())};
        add_elem(h, i == len - 1);
      end
    end
    total_items = elem_q.size();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (accepted_cnt == total_items && sig_exp_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sigmoid_fp16_with_max_scale regression: pass");
    end else begin
      $display("sigmoid_fp16_with_max_scale regression: fail");
    end
    $finish;
  end

endmodule
